// ===== rtl/arpp_pkg.sv =====
// arpp_pkg: shared types and constants of the arp request to probe block
`timescale 1ns / 1ps

package arpp_pkg;

  // protocol constants
  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [15:0] HW_TYPE_ETH   = 16'h0001;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_OPER_REQ  = 16'h0001;
  localparam logic [7:0]  ECHO_REQ_TYPE = 8'd8;
  localparam logic [7:0]  ARP_HW_LEN    = 8'd6;
  localparam logic [7:0]  ARP_PROTO_LEN = 8'd4;
  localparam logic [7:0]  BCAST_BYTE    = 8'hff;

  // byte positions within the frame
  localparam logic [5:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [5:0] ETHER_HDR_LEN = 6'd14;
  localparam logic [5:0] POS_HTYPE_LO  = 6'd15;
  localparam logic [5:0] POS_PTYPE_HI  = 6'd16;
  localparam logic [5:0] POS_PTYPE_LO  = 6'd17;
  localparam logic [5:0] POS_HLEN      = 6'd18;
  localparam logic [5:0] POS_PLEN      = 6'd19;
  localparam logic [5:0] POS_OPER_HI   = 6'd20;
  localparam logic [5:0] POS_OPER_LO   = 6'd21;
  localparam logic [5:0] POS_SHA_FIRST = 6'd22;
  localparam logic [5:0] POS_SHA_LAST  = 6'd27;
  localparam logic [5:0] POS_SPA_FIRST = 6'd28;
  localparam logic [5:0] POS_SPA_LAST  = 6'd31;
  localparam logic [5:0] POS_TPA_FIRST = 6'd38;
  localparam logic [5:0] POS_TPA_LAST  = 6'd41;
  localparam logic [5:0] FRAME_LEN     = 6'd42;

  // configuration register indexes
  localparam logic [2:0] CFG_RANGE_ACTIONS = 3'd5;
  localparam logic [2:0] CFG_RANGE_COUNT   = 3'd6;
  localparam logic [2:0] CFG_PROBE_IDENT   = 3'd7;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SUM_W      = 21;

  typedef enum logic [2:0] {
    VERDICT_PROBE      = 3'd0,
    VERDICT_ETHER_SHORT = 3'd1,
    VERDICT_ARP_SHORT  = 3'd2,
    VERDICT_BAD_HEADER = 3'd3,
    VERDICT_BAD_ARP    = 3'd4,
    VERDICT_FILTERED   = 3'd5
  } verdict_e;

  // per-frame parse state
  typedef struct packed {
    logic [5:0]       pos;
    logic             hdr_bad;
    logic             arp_inv;
    logic             sha_ones;
    logic [31:0]      sender_ip;
    logic [31:0]      target_ip;
    logic [SUM_W-1:0] sum;
  } frame_t;

endpackage

// ===== rtl/arpp_if.sv =====
// arpp_if: valid/ready channel interfaces for frame bytes and probe results
`timescale 1ns / 1ps

interface arpp_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface arpp_result_if;
  logic               valid;
  logic               ready;
  arpp_pkg::verdict_e verdict;
  logic [15:0]        probe_seq;
  logic [15:0]        probe_checksum;
  logic [31:0]        target_ip;

  modport source (output valid, output verdict, output probe_seq, output probe_checksum,
                  output target_ip, input ready);
  modport sink   (input valid, input verdict, input probe_seq, input probe_checksum,
                  input target_ip, output ready);
endinterface

// ===== rtl/arpp_addr_filter.sv =====
// arpp_addr_filter: first-match address range filter
`timescale 1ns / 1ps

module arpp_addr_filter #(
  parameter int unsigned MAX_RANGES = 5
) (
  input  logic [MAX_RANGES-1:0][63:0] bounds_i,
  input  logic [MAX_RANGES-1:0]       actions_i,
  input  logic [2:0]                  count_i,
  input  logic [31:0]                 addr_i,
  output logic                        reject_o
);

  logic [2:0] count_eff;

  assign count_eff = (count_i > 3'(MAX_RANGES)) ? 3'(MAX_RANGES) : count_i;

  // descending scan so the lowest matching range wins
  always_comb begin
    reject_o = 1'b1;
    for (int i = MAX_RANGES - 1; i >= 0; i--) begin
      if ((3'(i) < count_eff) && (addr_i >= bounds_i[i][63:32]) &&
          (addr_i <= bounds_i[i][31:0])) begin
        reject_o = actions_i[i];
      end
    end
  end

endmodule

// ===== rtl/arp_request_to_probe_unit.sv =====
// arp_request_to_probe_unit: parses arp request frames and builds echo probe results
// a frame's last byte loads the snapshot register, which feeds the result register
// throughput: one byte per cycle if output is free; any-length frames back to back
// the per-byte parse state updates on each transfer; a snapshot stage then runs the
// address filter and checksum fold into the result register
// reset: asynchronous active low; clears config registers, parse state and sequence
`timescale 1ns / 1ps

module arp_request_to_probe_unit #(
  parameter int unsigned MAX_RANGES = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  arpp_frame_if.sink                         frame_i,
  arpp_result_if.source                      result_o,
  input  logic                               cfg_we_i,
  input  logic [arpp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [arpp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // configuration
  logic [MAX_RANGES-1:0][63:0] bounds_q;
  logic [MAX_RANGES-1:0]       actions_q;
  logic [2:0]                  count_q;
  logic [15:0]                 ident_q;

  // pipeline
  arpp_pkg::frame_t   frame_q, frame_d, snap_q;
  logic               snap_valid_q;
  logic               out_valid_q;
  arpp_pkg::verdict_e verdict_q, verdict_d;
  logic [15:0]        seq_out_q, cksum_q, cksum_d;
  logic [31:0]        tip_q;
  logic [15:0]        seq_q;

  logic in_xfer, out_load, snap_move;
  logic rej_sender, rej_target;

  logic [21:0] s1;
  logic [16:0] f1;
  logic [15:0] f2;

  assign out_load       = !out_valid_q || result_o.ready;
  assign snap_move      = snap_valid_q && out_load;
  assign frame_i.ready  = !snap_valid_q || out_load;
  assign in_xfer        = frame_i.valid && frame_i.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q  <= '0;
      actions_q <= '0;
      count_q   <= '0;
      ident_q   <= '0;
    end else if (cfg_we_i) begin
      for (int i = 0; i < MAX_RANGES; i++) begin
        if (cfg_idx_i == 3'(i)) begin
          bounds_q[i] <= cfg_data_i;
        end
      end
      if (cfg_idx_i == arpp_pkg::CFG_RANGE_ACTIONS) begin
        actions_q <= cfg_data_i[MAX_RANGES-1:0];
      end
      if (cfg_idx_i == arpp_pkg::CFG_RANGE_COUNT) begin
        count_q <= cfg_data_i[2:0];
      end
      if (cfg_idx_i == arpp_pkg::CFG_PROBE_IDENT) begin
        ident_q <= cfg_data_i[15:0];
      end
    end
  end

  // per-byte parse
  always_comb begin
    logic [7:0] b;
    logic [5:0] p;
    logic       fault_hdr, fault_arp, sha_next;
    b         = frame_i.frame_byte;
    p         = frame_q.pos;
    frame_d   = frame_q;
    fault_hdr = 1'b0;
    fault_arp = 1'b0;
    sha_next  = frame_q.sha_ones;
    if (p < arpp_pkg::FRAME_LEN) begin
      frame_d.pos = p + 6'd1;
      unique case (p)
        arpp_pkg::POS_ETYPE_HI:  fault_hdr = (b != arpp_pkg::ETH_TYPE_ARP[15:8]);
        arpp_pkg::POS_ETYPE_LO:  fault_hdr = (b != arpp_pkg::ETH_TYPE_ARP[7:0]);
        arpp_pkg::ETHER_HDR_LEN: fault_hdr = (b != arpp_pkg::HW_TYPE_ETH[15:8]);
        arpp_pkg::POS_HTYPE_LO:  fault_hdr = (b != arpp_pkg::HW_TYPE_ETH[7:0]);
        arpp_pkg::POS_PTYPE_HI:  fault_hdr = (b != arpp_pkg::ETH_TYPE_IPV4[15:8]);
        arpp_pkg::POS_PTYPE_LO:  fault_hdr = (b != arpp_pkg::ETH_TYPE_IPV4[7:0]);
        arpp_pkg::POS_HLEN:      fault_arp = (b != arpp_pkg::ARP_HW_LEN);
        arpp_pkg::POS_PLEN:      fault_arp = (b != arpp_pkg::ARP_PROTO_LEN);
        arpp_pkg::POS_OPER_HI:   fault_hdr = (b != arpp_pkg::ARP_OPER_REQ[15:8]);
        arpp_pkg::POS_OPER_LO:   fault_hdr = (b != arpp_pkg::ARP_OPER_REQ[7:0]);
        default: ;
      endcase
      if (p >= arpp_pkg::POS_SHA_FIRST && p <= arpp_pkg::POS_SHA_LAST) begin
        if (p == arpp_pkg::POS_SHA_FIRST) begin
          sha_next = (b == arpp_pkg::BCAST_BYTE);
        end else begin
          sha_next = frame_q.sha_ones && (b == arpp_pkg::BCAST_BYTE);
        end
        if (p == arpp_pkg::POS_SHA_LAST) begin
          fault_arp = sha_next;
        end
      end
      frame_d.sha_ones = sha_next;
      // first fault wins
      if (!frame_q.hdr_bad && !frame_q.arp_inv) begin
        frame_d.hdr_bad = fault_hdr;
        frame_d.arp_inv = fault_arp;
      end
      if (p >= arpp_pkg::POS_SPA_FIRST && p <= arpp_pkg::POS_SPA_LAST) begin
        frame_d.sender_ip = {frame_q.sender_ip[23:0], b};
      end
      if (p >= arpp_pkg::POS_TPA_FIRST && p <= arpp_pkg::POS_TPA_LAST) begin
        frame_d.target_ip = {frame_q.target_ip[23:0], b};
      end
      if (p >= arpp_pkg::ETHER_HDR_LEN) begin
        if (!p[0]) begin
          frame_d.sum = frame_q.sum + {5'd0, b, 8'd0};
        end else begin
          frame_d.sum = frame_q.sum + {13'd0, b};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q      <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        frame_q <= frame_i.last_byte ? '0 : frame_d;
      end
      if (in_xfer && frame_i.last_byte) begin
        snap_valid_q <= 1'b1;
      end else if (snap_move) begin
        snap_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && frame_i.last_byte) begin
      snap_q <= frame_d;
    end
  end

  // verdict stage
  arpp_addr_filter #(.MAX_RANGES(MAX_RANGES)) u_filt_sender (
    .bounds_i  (bounds_q),
    .actions_i (actions_q),
    .count_i   (count_q),
    .addr_i    (snap_q.sender_ip),
    .reject_o  (rej_sender)
  );

  arpp_addr_filter #(.MAX_RANGES(MAX_RANGES)) u_filt_target (
    .bounds_i  (bounds_q),
    .actions_i (actions_q),
    .count_i   (count_q),
    .addr_i    (snap_q.target_ip),
    .reject_o  (rej_target)
  );

  always_comb begin
    priority if (snap_q.pos < arpp_pkg::ETHER_HDR_LEN) begin
      verdict_d = arpp_pkg::VERDICT_ETHER_SHORT;
    end else if (snap_q.pos < arpp_pkg::FRAME_LEN) begin
      verdict_d = arpp_pkg::VERDICT_ARP_SHORT;
    end else if (snap_q.hdr_bad) begin
      verdict_d = arpp_pkg::VERDICT_BAD_HEADER;
    end else if (snap_q.arp_inv) begin
      verdict_d = arpp_pkg::VERDICT_BAD_ARP;
    end else if ((count_q != 3'd0) && (rej_sender || rej_target)) begin
      verdict_d = arpp_pkg::VERDICT_FILTERED;
    end else begin
      verdict_d = arpp_pkg::VERDICT_PROBE;
    end
  end

  // echo header plus arp body, end-around carry fold
  assign s1      = {1'b0, snap_q.sum} + {6'd0, arpp_pkg::ECHO_REQ_TYPE, 8'd0} +
                   {6'd0, ident_q} + {6'd0, seq_q};
  assign f1      = {1'b0, s1[15:0]} + {11'd0, s1[21:16]};
  assign f2      = f1[15:0] + {15'd0, f1[16]};
  assign cksum_d = ~f2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      seq_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= snap_valid_q;
      end
      if (snap_move && verdict_d == arpp_pkg::VERDICT_PROBE) begin
        seq_q <= seq_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_move) begin
      verdict_q <= verdict_d;
      if (verdict_d == arpp_pkg::VERDICT_PROBE) begin
        seq_out_q <= seq_q;
        cksum_q   <= cksum_d;
        tip_q     <= snap_q.target_ip;
      end else begin
        seq_out_q <= '0;
        cksum_q   <= '0;
        tip_q     <= '0;
      end
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.verdict        = verdict_q;
  assign result_o.probe_seq      = seq_out_q;
  assign result_o.probe_checksum = cksum_q;
  assign result_o.target_ip      = tip_q;

endmodule

// ===== rtl/arpp_checker.sv =====
// arpp_checker: port-level assertions for the arp request to probe unit
`timescale 1ns / 1ps

module arpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_verdict_i,
  input logic [15:0] out_seq_i,
  input logic [15:0] out_cksum_i,
  input logic [31:0] out_tip_i
);

  logic [1:0]  pending_q;
  logic [15:0] last_seq_q;
  logic        have_seq_q;
  logic        in_end, out_xfer, out_probe;

  assign in_end    = in_valid_i && in_ready_i && in_last_i;
  assign out_xfer  = out_valid_i && out_ready_i;
  assign out_probe = out_xfer && (out_verdict_i == arpp_pkg::VERDICT_PROBE);

  // frames ended but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      last_seq_q <= '0;
      have_seq_q <= 1'b0;
    end else begin
      pending_q <= pending_q + {1'b0, in_end} - {1'b0, out_xfer};
      if (out_probe) begin
        last_seq_q <= out_seq_i;
        have_seq_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_verdict_i) &&
    $stable(out_seq_i) && $stable(out_cksum_i) && $stable(out_tip_i))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result without a finished frame");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_verdict_i != arpp_pkg::VERDICT_PROBE |->
    out_seq_i == 16'd0 && out_cksum_i == 16'd0 && out_tip_i == 32'd0)
    else $error("rejected frame carries probe fields");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_probe && have_seq_q |-> out_seq_i == last_seq_q + 16'd1)
    else $error("probe sequence did not advance by one");

endmodule

bind arp_request_to_probe_unit arpp_checker u_arpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (frame_i.valid),
  .in_ready_i    (frame_i.ready),
  .in_last_i     (frame_i.last_byte),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_verdict_i (result_o.verdict),
  .out_seq_i     (result_o.probe_seq),
  .out_cksum_i   (result_o.probe_checksum),
  .out_tip_i     (result_o.target_ip)
);

// ===== tb/arp_request_to_probe_unit_test.sv =====
// arp_request_to_probe_unit_test: checks arp verdicts, echo probe fields and the address filter
`timescale 1ns / 1ps

module arp_request_to_probe_unit_test;

  localparam int unsigned MAX_RANGES = 5;
  localparam logic [2:0] CFG_RANGE_BOUNDS_0 = 3'd0;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 400;

  typedef struct {
    arpp_pkg::verdict_e verdict;
    logic [15:0]        seq;
    logic [15:0]        checksum;
    logic [31:0]        dest_ip;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [arpp_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [arpp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  arpp_frame_if frame_if ();
  arpp_result_if result_if ();

  arp_request_to_probe_unit #(
    .MAX_RANGES(MAX_RANGES)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frame_i   (frame_if),
    .result_o  (result_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of configuration and parse state
  logic [63:0] cfg_bounds [MAX_RANGES] = '{default: '0};
  logic [4:0]  cfg_actions = '0;
  logic [2:0]  cfg_count = '0;
  logic [15:0] cfg_ident = '0;
  logic [5:0]  frame_pos = '0;
  logic        hdr_bad = 1'b0;
  logic        arp_inv = 1'b0;
  logic        sha_ones = 1'b0;
  logic [31:0] sender_addr = '0;
  logic [31:0] target_addr = '0;
  logic [20:0] word_sum = '0;
  logic [15:0] next_seq = '0;

  verdict_t verdicts_due[$];
  logic [7:0] frame_q[$];

  int errors = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int cfg_writes = 0;
  int verdicts_seen [6] = '{default: 0};
  int burst_left = 0;
  int quiet_cycles = 0;
  int rx_tick = 0;
  bit idle_on = 1'b0;
  bit stall_on = 1'b0;

  function automatic void note_fault(logic cond, logic is_hdr);
    if (cond && !hdr_bad && !arp_inv) begin
      if (is_hdr) hdr_bad = 1'b1;
      else arp_inv = 1'b1;
    end
  endfunction

  function automatic void parse_byte(logic [5:0] p, logic [7:0] b);
    case (p)
      arpp_pkg::POS_ETYPE_HI:  note_fault(b != arpp_pkg::ETH_TYPE_ARP[15:8], 1'b1);
      arpp_pkg::POS_ETYPE_LO:  note_fault(b != arpp_pkg::ETH_TYPE_ARP[7:0], 1'b1);
      arpp_pkg::ETHER_HDR_LEN: note_fault(b != arpp_pkg::HW_TYPE_ETH[15:8], 1'b1);
      arpp_pkg::POS_HTYPE_LO:  note_fault(b != arpp_pkg::HW_TYPE_ETH[7:0], 1'b1);
      arpp_pkg::POS_PTYPE_HI:  note_fault(b != arpp_pkg::ETH_TYPE_IPV4[15:8], 1'b1);
      arpp_pkg::POS_PTYPE_LO:  note_fault(b != arpp_pkg::ETH_TYPE_IPV4[7:0], 1'b1);
      arpp_pkg::POS_HLEN:      note_fault(b != arpp_pkg::ARP_HW_LEN, 1'b0);
      arpp_pkg::POS_PLEN:      note_fault(b != arpp_pkg::ARP_PROTO_LEN, 1'b0);
      arpp_pkg::POS_OPER_HI:   note_fault(b != arpp_pkg::ARP_OPER_REQ[15:8], 1'b1);
      arpp_pkg::POS_OPER_LO:   note_fault(b != arpp_pkg::ARP_OPER_REQ[7:0], 1'b1);
      default: ;
    endcase
    if (p >= arpp_pkg::POS_SHA_FIRST && p <= arpp_pkg::POS_SHA_LAST) begin
      if (p == arpp_pkg::POS_SHA_FIRST) sha_ones = 1'b1;
      if (b != arpp_pkg::BCAST_BYTE) sha_ones = 1'b0;
      if (p == arpp_pkg::POS_SHA_LAST) note_fault(sha_ones, 1'b0);
    end
    if (p >= arpp_pkg::POS_SPA_FIRST && p <= arpp_pkg::POS_SPA_LAST)
      sender_addr = {sender_addr[23:0], b};
    if (p >= arpp_pkg::POS_TPA_FIRST && p <= arpp_pkg::POS_TPA_LAST)
      target_addr = {target_addr[23:0], b};
    // even offsets from the arp body start are the high byte of a word
    if (p >= arpp_pkg::ETHER_HDR_LEN)
      word_sum = word_sum + (p[0] ? {13'd0, b} : {5'd0, b, 8'd0});
  endfunction

  function automatic logic addr_rejected(logic [31:0] a);
    int n;
    n = (cfg_count > MAX_RANGES) ? MAX_RANGES : cfg_count;
    for (int i = 0; i < n; i++) begin
      if (a >= cfg_bounds[i][63:32] && a <= cfg_bounds[i][31:0]) return cfg_actions[i];
    end
    return 1'b1;
  endfunction

  function automatic void predict_verdict(logic [7:0] b, logic last);
    verdict_t r;
    logic [31:0] s;
    if (frame_pos < arpp_pkg::FRAME_LEN) begin
      parse_byte(frame_pos, b);
      frame_pos++;
    end
    if (!last) return;
    r.seq = '0;
    r.checksum = '0;
    r.dest_ip = '0;
    if (frame_pos < arpp_pkg::ETHER_HDR_LEN) r.verdict = arpp_pkg::VERDICT_ETHER_SHORT;
    else if (frame_pos < arpp_pkg::FRAME_LEN) r.verdict = arpp_pkg::VERDICT_ARP_SHORT;
    else if (hdr_bad) r.verdict = arpp_pkg::VERDICT_BAD_HEADER;
    else if (arp_inv) r.verdict = arpp_pkg::VERDICT_BAD_ARP;
    else if (cfg_count != 0 && (addr_rejected(sender_addr) || addr_rejected(target_addr)))
      r.verdict = arpp_pkg::VERDICT_FILTERED;
    else r.verdict = arpp_pkg::VERDICT_PROBE;
    if (r.verdict == arpp_pkg::VERDICT_PROBE) begin
      r.seq = next_seq;
      next_seq++;
      s = {11'd0, word_sum} + {16'd0, arpp_pkg::ECHO_REQ_TYPE, 8'd0} + {16'd0, cfg_ident} +
          {16'd0, r.seq};
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      r.checksum = ~s[15:0];
      r.dest_ip = target_addr;
    end
    verdicts_due.push_back(r);
    frame_pos = '0;
    hdr_bad = 1'b0;
    arp_inv = 1'b0;
    sha_ones = 1'b0;
    sender_addr = '0;
    target_addr = '0;
    word_sum = '0;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      arpp_pkg::CFG_RANGE_ACTIONS: cfg_actions = data[4:0];
      arpp_pkg::CFG_RANGE_COUNT:   cfg_count = data[2:0];
      arpp_pkg::CFG_PROBE_IDENT:   cfg_ident = data[15:0];
      default:                     cfg_bounds[idx] = data;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        frame_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    frame_if.valid <= 1'b1;
    frame_if.frame_byte <= b;
    frame_if.last_byte <= last;
    burst_left--;
    do @(posedge clk_i); while (!frame_if.ready);
    predict_verdict(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
    frames_sent++;
  endtask

  // stop sending, let every verdict arrive, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    frame_if.valid <= 1'b0;
    burst_left = 0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void build_request(logic [31:0] sender, logic [31:0] target);
    frame_q.delete();
    repeat (12) frame_q.push_back(8'($urandom()));
    frame_q.push_back(arpp_pkg::ETH_TYPE_ARP[15:8]);
    frame_q.push_back(arpp_pkg::ETH_TYPE_ARP[7:0]);
    frame_q.push_back(arpp_pkg::HW_TYPE_ETH[15:8]);
    frame_q.push_back(arpp_pkg::HW_TYPE_ETH[7:0]);
    frame_q.push_back(arpp_pkg::ETH_TYPE_IPV4[15:8]);
    frame_q.push_back(arpp_pkg::ETH_TYPE_IPV4[7:0]);
    frame_q.push_back(arpp_pkg::ARP_HW_LEN);
    frame_q.push_back(arpp_pkg::ARP_PROTO_LEN);
    frame_q.push_back(arpp_pkg::ARP_OPER_REQ[15:8]);
    frame_q.push_back(arpp_pkg::ARP_OPER_REQ[7:0]);
    repeat (6) frame_q.push_back(8'($urandom()));
    for (int k = 3; k >= 0; k--) frame_q.push_back(sender[8*k +: 8]);
    repeat (6) frame_q.push_back(8'($urandom()));
    for (int k = 3; k >= 0; k--) frame_q.push_back(target[8*k +: 8]);
  endfunction

  function automatic void trim_frame(int n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endfunction

  function automatic void flip_byte(int p);
    frame_q[p] = frame_q[p] ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic void broadcast_sha();
    for (int p = arpp_pkg::POS_SHA_FIRST; p <= arpp_pkg::POS_SHA_LAST; p++)
      frame_q[p] = arpp_pkg::BCAST_BYTE;
  endfunction

  function automatic logic [63:0] random_bounds();
    logic [31:0] lo, hi;
    logic [32:0] top;
    lo = $urandom();
    case ($urandom_range(0, 5))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: hi = lo;
      2: hi = lo - 32'($urandom_range(1, 1000));
      default: begin
        top = {1'b0, lo} + 33'($urandom_range(0, 1 << 20));
        hi = top[32] ? '1 : top[31:0];
      end
    endcase
    return {lo, hi};
  endfunction

  // addresses near and on the configured range edges, plus fully random ones
  function automatic logic [31:0] pick_addr();
    int i;
    i = $urandom_range(0, MAX_RANGES - 1);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return cfg_bounds[i][63:32];
      2: return cfg_bounds[i][31:0];
      3: return cfg_bounds[i][63:32] - 32'd1;
      4: return cfg_bounds[i][31:0] + 32'd1;
      default: return cfg_bounds[i][63:32] + 32'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void make_random_frame();
    int kind, n;
    kind = $urandom_range(0, 19);
    build_request(pick_addr(), pick_addr());
    case (kind)
      12: broadcast_sha();
      13, 14: flip_byte($urandom_range(arpp_pkg::POS_ETYPE_HI, arpp_pkg::POS_SHA_LAST));
      15: trim_frame($urandom_range(1, arpp_pkg::FRAME_LEN - 1));
      16: repeat ($urandom_range(1, 28)) frame_q.push_back(8'($urandom()));
      17: begin
        n = $urandom_range(1, 60);
        frame_q.delete();
        repeat (n) frame_q.push_back(8'($urandom()));
      end
      18: begin
        flip_byte($urandom_range(arpp_pkg::POS_HLEN, arpp_pkg::POS_PLEN));
        flip_byte($urandom_range(arpp_pkg::POS_OPER_HI, arpp_pkg::POS_OPER_LO));
      end
      19: begin
        broadcast_sha();
        flip_byte($urandom_range(arpp_pkg::POS_SHA_FIRST, arpp_pkg::POS_SHA_LAST));
      end
      default: ;
    endcase
  endfunction

  task automatic test_directed_verdicts();
    logic [5:0] hdr_pos [8];
    int lens [4];
    hdr_pos = '{arpp_pkg::POS_ETYPE_HI, arpp_pkg::POS_ETYPE_LO, arpp_pkg::ETHER_HDR_LEN,
                arpp_pkg::POS_HTYPE_LO, arpp_pkg::POS_PTYPE_HI, arpp_pkg::POS_PTYPE_LO,
                arpp_pkg::POS_OPER_HI, arpp_pkg::POS_OPER_LO};
    lens = '{1, 13, 14, 41};
    idle_on = 1'b1;
    stall_on = 1'b1;
    write_reg(arpp_pkg::CFG_PROBE_IDENT, 64'hffff);
    build_request($urandom(), $urandom());
    send_frame();
    build_request('0, '1);
    send_frame();
    build_request('1, '0);
    send_frame();
    foreach (lens[k]) begin
      build_request($urandom(), $urandom());
      trim_frame(lens[k]);
      send_frame();
    end
    // bytes past the arp body are ignored
    build_request($urandom(), $urandom());
    repeat (22) frame_q.push_back(8'($urandom()));
    send_frame();
    frame_q.delete();
    repeat (arpp_pkg::FRAME_LEN) frame_q.push_back(8'h00);
    send_frame();
    frame_q.delete();
    repeat (arpp_pkg::FRAME_LEN) frame_q.push_back(8'hff);
    send_frame();
    foreach (hdr_pos[k]) begin
      build_request($urandom(), $urandom());
      flip_byte(hdr_pos[k]);
      send_frame();
    end
    build_request($urandom(), $urandom());
    flip_byte(arpp_pkg::POS_HLEN);
    send_frame();
    build_request($urandom(), $urandom());
    flip_byte(arpp_pkg::POS_PLEN);
    send_frame();
    build_request($urandom(), $urandom());
    broadcast_sha();
    send_frame();
    build_request($urandom(), $urandom());
    broadcast_sha();
    frame_q[arpp_pkg::POS_SHA_LAST] = 8'hfe;
    send_frame();
    // first fault in byte order wins
    build_request($urandom(), $urandom());
    flip_byte(arpp_pkg::POS_HLEN);
    flip_byte(arpp_pkg::POS_OPER_HI);
    send_frame();
    build_request($urandom(), $urandom());
    flip_byte(arpp_pkg::POS_ETYPE_LO);
    flip_byte(arpp_pkg::POS_HLEN);
    send_frame();
    build_request($urandom(), $urandom());
    broadcast_sha();
    flip_byte(arpp_pkg::POS_OPER_LO);
    send_frame();
    drain();
  endtask

  task automatic test_address_filter();
    for (int setting = 0; setting < 7; setting++) begin
      for (int r = 0; r < MAX_RANGES; r++)
        write_reg(3'(CFG_RANGE_BOUNDS_0 + r), random_bounds());
      case (setting)
        0: begin
          write_reg(CFG_RANGE_BOUNDS_0, {32'h0, 32'hffff_ffff});
          write_reg(arpp_pkg::CFG_RANGE_ACTIONS, 64'h0);
          write_reg(arpp_pkg::CFG_RANGE_COUNT, 64'd1);
        end
        1: begin
          write_reg(CFG_RANGE_BOUNDS_0, {32'h0, 32'hffff_ffff});
          write_reg(arpp_pkg::CFG_RANGE_ACTIONS, 64'h1f);
          write_reg(arpp_pkg::CFG_RANGE_COUNT, 64'd1);
        end
        2: begin
          write_reg(arpp_pkg::CFG_RANGE_ACTIONS, 64'($urandom_range(0, 31)));
          write_reg(arpp_pkg::CFG_RANGE_COUNT, 64'd5);
        end
        3: begin
          write_reg(arpp_pkg::CFG_RANGE_ACTIONS, 64'($urandom_range(0, 31)));
          write_reg(arpp_pkg::CFG_RANGE_COUNT, 64'd7);
        end
        4: begin
          write_reg(arpp_pkg::CFG_RANGE_ACTIONS, 64'h0);
          write_reg(arpp_pkg::CFG_RANGE_COUNT, 64'd2);
        end
        5: begin
          write_reg(arpp_pkg::CFG_RANGE_ACTIONS, 64'h1f);
          write_reg(arpp_pkg::CFG_RANGE_COUNT, 64'd5);
        end
        default: begin
          write_reg(arpp_pkg::CFG_RANGE_ACTIONS, 64'h0);
          write_reg(arpp_pkg::CFG_RANGE_COUNT, 64'd0);
        end
      endcase
      write_reg(arpp_pkg::CFG_PROBE_IDENT,
                (setting == 0) ? 64'h0 : 64'($urandom_range(0, 65535)));
      repeat (1) begin
        build_request(pick_addr(), pick_addr());
        send_frame();
      end
      drain();
    end
  endtask

  task automatic test_random_traffic();
    int phase_start;
    for (int phase = 0; phase < 4; phase++) begin
      for (int r = 0; r < MAX_RANGES; r++)
        write_reg(3'(CFG_RANGE_BOUNDS_0 + r), random_bounds());
      write_reg(arpp_pkg::CFG_RANGE_ACTIONS, 64'($urandom_range(0, 31)));
      write_reg(arpp_pkg::CFG_RANGE_COUNT, 64'($urandom_range(0, 7)));
      write_reg(arpp_pkg::CFG_PROBE_IDENT, 64'($urandom_range(0, 65535)));
      idle_on = (phase % 2 == 1);
      stall_on = (phase >= 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 30) begin
        make_random_frame();
        send_frame();
      end
      drain();
    end
  endtask

  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (!stall_on) result_if.ready <= 1'b1;
    else result_if.ready <= (rx_tick % 7 != 3) && (rx_tick % 11 != 5) &&
                            ($urandom_range(0, 4) != 0);
  end

  always @(posedge clk_i) begin : check_results
    verdict_t due;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict: none pending, got %0d", result_if.verdict);
        errors++;
      end else begin
        due = verdicts_due.pop_front();
        if (result_if.verdict !== due.verdict) begin
          $error("verdict: expected %0d, got %0d", due.verdict, result_if.verdict);
          errors++;
        end
        if (result_if.probe_seq !== due.seq) begin
          $error("probe_seq: expected %0h, got %0h", due.seq, result_if.probe_seq);
          errors++;
        end
        if (result_if.probe_checksum !== due.checksum) begin
          $error("probe_checksum: expected %0h, got %0h", due.checksum,
                 result_if.probe_checksum);
          errors++;
        end
        if (result_if.target_ip !== due.dest_ip) begin
          $error("target_ip: expected %0h, got %0h", due.dest_ip, result_if.target_ip);
          errors++;
        end
        verdicts_seen[due.verdict]++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    frame_if.valid = 1'b0;
    frame_if.frame_byte = '0;
    frame_if.last_byte = 1'b0;
    result_if.ready = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_verdicts();
    test_address_filter();
    test_random_traffic();
    $display("sent %0d frames in %0d bytes across %0d register writes", frames_sent,
             bytes_sent, cfg_writes);
    $display("verdicts: probe %0d, ether short %0d, arp short %0d, header %0d, arp %0d, %s %0d",
             verdicts_seen[0], verdicts_seen[1], verdicts_seen[2], verdicts_seen[3],
             verdicts_seen[4], "filtered", verdicts_seen[5]);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
